### rtl/cfpb_pkg.sv
package cfpb_pkg;

  // Reflected CRC-8/MAXIM polynomial; init is zero, with no final xor.
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  // Reset value of the start-of-frame marker register.
  localparam logic [7:0] HeaderReset = 8'hAA;

  // Default payload buffer depth in bytes (legal range 1 to 255).
  localparam int unsigned MaxPayloadDefault = 32;

  // One result byte as it leaves the sequencer.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       ovf;
  } out_beat_t;

endpackage

### rtl/crc8_framed_packet_builder_unit.sv
// Framed packet builder with a CRC-8/MAXIM trailer.
// The slave stream carries one message item per request: tdata holds the
// frame type and a data byte, tuser flags that the data byte is present, and
// tlast closes the message. Items without tlast are taken back to back while
// the block is idle; the payload byte goes into a buffer of MaxPayload
// bytes, and bytes past that are dropped and flagged.
// On the item with tlast the block stops taking input and emits the frame on
// the master stream, one byte per cycle while the receiver is ready: header,
// type, length, payload, CRC. The request with tlast moves the sequencer to
// its header state, and the header byte is presented once the output
// register has loaded it; a frame of N payload bytes is N + 4 bytes long, and
// input is ready again in the cycle that presents the CRC byte. The single
// CRC unit folds in each emitted byte; the buffer read port feeds the payload.
// tlast on the master side marks the CRC byte; tuser marks a frame whose
// message lost bytes. A receiver stall freezes the sequencer with the
// current byte held in the output register.
// The header marker comes from the configuration channel, which is always
// ready and should be written only while the block is idle.
// Reset returns the block to idle with an empty buffer and header 0xAA.
module crc8_framed_packet_builder_unit #(
  parameter int unsigned MaxPayload = cfpb_pkg::MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: header byte.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] frame_type, [15:8] data_byte
  input  logic        s_axis_tuser,  // [0] has_byte
  input  logic        s_axis_tlast,  // last
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tuser,  // [0] overflow
  output logic        m_axis_tlast   // end_of_frame
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned CntW  = $clog2(MaxPayload + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHdr  = 3'd1;
  localparam logic [2:0] StType = 3'd2;
  localparam logic [2:0] StLen  = 3'd3;
  localparam logic [2:0] StPay  = 3'd4;
  localparam logic [2:0] StCrc  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [7:0]      header_q;
  logic [7:0]      type_q, type_d;
  logic            in_frame_q, in_frame_d;
  logic            dropped_q, dropped_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      crc_next;
  logic [7:0]      rd_data;
  logic            out_valid_q, out_valid_d;
  cfpb_pkg::out_beat_t out_q, out_d;
  cfpb_pkg::out_beat_t beat;
  logic            in_req;
  logic            can_load;
  logic            wr_en;

  // Header register; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= cfpb_pkg::HeaderReset;
    end else if (cfg_valid_i) begin
      header_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign can_load      = !out_valid_q || m_axis_tready;
  assign wr_en         = in_req && s_axis_tuser && (cnt_q < CntW'(MaxPayload));

  // Payload buffer; the read address is the next index so data is ready in time.
  cfpb_payload_mem #(
    .Depth (MaxPayload),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (s_axis_tdata[15:8]),
    .rd_addr_i (idx_d[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // Byte presented to the output in each emitting state.
  always_comb begin
    beat.eof = 1'b0;
    beat.ovf = dropped_q;
    case (state_q)
      StHdr:   beat.data = header_q;
      StType:  beat.data = type_q;
      StLen:   beat.data = 8'(cnt_q);
      StPay:   beat.data = rd_data;
      StCrc: begin
        beat.data = crc_q;
        beat.eof  = 1'b1;
      end
      default: beat.data = 8'h00;
    endcase
  end

  // The one CRC unit, fed with each frame byte as it is emitted.
  cfpb_crc_unit u_crc (
    .crc_i  (crc_q),
    .data_i (beat.data),
    .crc_o  (crc_next)
  );

  // Sequencer: collect payload while idle, then walk the frame byte by byte.
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    in_frame_d  = in_frame_q;
    dropped_d   = dropped_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (state_q == StIdle) begin
      if (in_req) begin
        if (!in_frame_q) begin
          type_d     = s_axis_tdata[7:0];
          in_frame_d = 1'b1;
        end
        if (wr_en) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (s_axis_tuser) begin
          dropped_d = 1'b1;
        end
        if (s_axis_tlast) begin
          state_d = StHdr;
        end
      end
    end else if (can_load) begin
      out_d       = beat;
      out_valid_d = 1'b1;
      crc_d       = crc_next;
      case (state_q)
        StHdr:  state_d = StType;
        StType: state_d = StLen;
        StLen: begin
          state_d = (cnt_q == '0) ? StCrc : StPay;
        end
        StPay: begin
          if (idx_q + CntW'(1) == cnt_q) begin
            state_d = StCrc;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
        StCrc: begin
          state_d    = StIdle;
          crc_d      = cfpb_pkg::CrcInit;
          cnt_d      = '0;
          in_frame_d = 1'b0;
          dropped_d  = 1'b0;
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      type_q      <= 8'h00;
      in_frame_q  <= 1'b0;
      dropped_q   <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      crc_q       <= cfpb_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      in_frame_q  <= in_frame_d;
      dropped_q   <= dropped_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register holds no control state.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tlast  = out_q.eof;
  assign m_axis_tuser  = out_q.ovf;

`ifndef SYNTHESIS
  // The stored byte count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPayload))
    else $error("payload count beyond buffer depth");

  // While walking the payload the read index stays inside the stored bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPay) |-> (idx_q < cnt_q))
    else $error("payload index past stored length");

  // Handing off the CRC byte leaves an empty message behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCrc && can_load) |=> (cnt_q == '0 && !in_frame_q && !dropped_q))
    else $error("message state not cleared after frame");
`endif

endmodule

### rtl/cfpb_crc_unit.sv
module cfpb_crc_unit (
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);

  // Fold one byte into the running checksum, LSB first.
  always_comb begin
    logic [7:0] c;
    c = crc_i ^ data_i;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ cfpb_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

### rtl/cfpb_payload_mem.sv
module cfpb_payload_mem #(
  parameter int unsigned Depth = cfpb_pkg::MaxPayloadDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### verif/crc8_framed_packet_builder_unit_tb.sv
module crc8_framed_packet_builder_unit_tb;

  localparam int unsigned MaxBytes = cfpb_pkg::MaxPayloadDefault;
  localparam int unsigned TotalItems = 160;
  localparam int unsigned IdlePct = 14;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DirectedRows = 15;

  // A table row either offers message items or rewrites the header marker.
  typedef enum logic {
    RowItem,
    RowHeader
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;   // header value on a RowHeader row
    logic        has_byte;
    logic        last;
    int unsigned reps;        // data byte counts up across repeats
    logic [7:0]  len_typed;   // length byte of the frame closed by this row
    logic        ovf_typed;   // overflow flag of the frame closed by this row
  } stim_row_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [7:0] len;
    logic       ovf;
  } frame_typed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;  // [7:0] frame_type, [15:8] data_byte
  logic        s_axis_tuser = 1'b0;      // [0] has_byte
  logic        s_axis_tlast = 1'b0;      // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;             // [7:0] out_byte
  logic        m_axis_tuser;             // [0] overflow
  logic        m_axis_tlast;             // end_of_frame

  // Shadow copy of the builder state, advanced on every accepted request and header write.
  logic [7:0]   hdr_shadow = cfpb_pkg::HeaderReset;
  logic [7:0]   payload_shadow [MaxBytes];
  int unsigned  count_shadow = 0;
  logic [7:0]   type_shadow = 8'h00;
  logic         open_shadow = 1'b0;
  logic         dropped_shadow = 1'b0;

  cfpb_pkg::out_beat_t frame_bytes_q[$];
  frame_typed_t typed_frames_q[$];
  int unsigned  err_count = 0;
  int unsigned  sent_items = 0;
  int unsigned  cycles = 0;
  bit           idle_on = 1'b1;

  stim_row_t directed_rows [DirectedRows] = '{
    // Shortest frame straight out of reset.
    '{RowItem,   8'h00, 8'h00, 1'b0, 1'b1, 1, 8'd0, 1'b0},
    // One byte carried by the closing request, all-ones fields.
    '{RowItem,   8'hFF, 8'hFF, 1'b1, 1'b1, 1, 8'd1, 1'b0},
    '{RowItem,   8'h5A, 8'h00, 1'b1, 1'b0, 1, 8'd0, 1'b0},
    // Empty request inside a message; its type must be ignored.
    '{RowItem,   8'hA5, 8'hFF, 1'b0, 1'b0, 1, 8'd0, 1'b0},
    '{RowItem,   8'h00, 8'h80, 1'b1, 1'b0, 1, 8'd0, 1'b0},
    // Closing request without a byte.
    '{RowItem,   8'hFF, 8'h01, 1'b0, 1'b1, 1, 8'd2, 1'b0},
    '{RowHeader, 8'h00, 8'h00, 1'b0, 1'b0, 1, 8'd0, 1'b0},
    '{RowItem,   8'h00, 8'h00, 1'b0, 1'b1, 1, 8'd0, 1'b0},
    '{RowHeader, 8'h00, 8'hFF, 1'b0, 1'b0, 1, 8'd0, 1'b0},
    '{RowItem,   8'hFF, 8'h7F, 1'b1, 1'b1, 1, 8'd1, 1'b0},
    // Fill the buffer, then drop the byte of the closing request.
    '{RowItem,   8'h3C, 8'h00, 1'b1, 1'b0, MaxBytes, 8'd0, 1'b0},
    '{RowItem,   8'hC3, 8'hEE, 1'b1, 1'b1, 1, 8'(MaxBytes), 1'b1},
    // The overflow flag must be clear on the next frame.
    '{RowItem,   8'h81, 8'h22, 1'b1, 1'b0, 1, 8'd0, 1'b0},
    '{RowItem,   8'h7E, 8'hDD, 1'b1, 1'b1, 1, 8'd2, 1'b0},
    '{RowHeader, 8'h00, cfpb_pkg::HeaderReset, 1'b0, 1'b0, 1, 8'd0, 1'b0}
  };

  crc8_framed_packet_builder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Reflected CRC-8/MAXIM update, one byte, LSB first.
  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cfpb_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the shadow state by one request and queue the frame it closes.
  task automatic build_frame(input msg_item_t it);
    logic [7:0]   crc;
    logic [7:0]   len;
    logic         ovf;
    frame_typed_t typed;
    if (!open_shadow) begin
      type_shadow = it.frame_type;
      open_shadow = 1'b1;
    end
    if (it.has_byte) begin
      if (count_shadow < MaxBytes) begin
        payload_shadow[count_shadow] = it.data_byte;
        count_shadow++;
      end else begin
        dropped_shadow = 1'b1;
      end
    end
    if (it.last) begin
      len = 8'(count_shadow);
      ovf = dropped_shadow;
      // Frames from the directed table carry hand-written length and flag.
      if (typed_frames_q.size() != 0) begin
        typed = typed_frames_q.pop_front();
        len = typed.len;
        ovf = typed.ovf;
      end
      crc = crc8_maxim(cfpb_pkg::CrcInit, hdr_shadow);
      frame_bytes_q.push_back(cfpb_pkg::out_beat_t'{hdr_shadow, 1'b0, ovf});
      crc = crc8_maxim(crc, type_shadow);
      frame_bytes_q.push_back(cfpb_pkg::out_beat_t'{type_shadow, 1'b0, ovf});
      crc = crc8_maxim(crc, len);
      frame_bytes_q.push_back(cfpb_pkg::out_beat_t'{len, 1'b0, ovf});
      for (int unsigned i = 0; i < count_shadow; i++) begin
        crc = crc8_maxim(crc, payload_shadow[i]);
        frame_bytes_q.push_back(cfpb_pkg::out_beat_t'{payload_shadow[i], 1'b0, ovf});
      end
      frame_bytes_q.push_back(cfpb_pkg::out_beat_t'{crc, 1'b1, ovf});
      count_shadow = 0;
      open_shadow = 1'b0;
      dropped_shadow = 1'b0;
    end
  endtask

  // Observe both streams and the configuration channel at the rising edge.
  always @(posedge clk_i) begin
    cfpb_pkg::out_beat_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        hdr_shadow = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        build_frame(msg_item_t'{s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser,
                                s_axis_tlast});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected frame byte %02h", m_axis_tdata);
          err_count++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
            err_count++;
          end
          if (m_axis_tlast !== want.eof) begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, m_axis_tlast);
            err_count++;
          end
          if (m_axis_tuser !== want.ovf) begin
            $error("overflow: expected %0b, actual %0b", want.ovf, m_axis_tuser);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver stalls at random while idling is enabled.
  always @(negedge clk_i) begin
    if (idle_on) begin
      m_axis_tready <= ($urandom_range(0, 99) >= IdlePct);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request; called and returning at a falling edge.
  task automatic send_item(input msg_item_t it);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.data_byte, it.frame_type};
    s_axis_tuser  <= it.has_byte;
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Wait with the input stream quiet until every frame byte has come out.
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (frame_bytes_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] value);
    drain_frames();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One well-formed message of n_bytes payload bytes, with empty requests
  // mixed in and the closing request carrying the final byte half the time.
  task automatic send_message(input int unsigned n_bytes);
    msg_item_t   it;
    int unsigned left;
    bit          carry_last;
    left = n_bytes;
    carry_last = (n_bytes != 0) && ($urandom_range(0, 1) == 1);
    forever begin
      it.frame_type = 8'($urandom_range(0, 255));
      it.data_byte  = 8'($urandom_range(0, 255));
      if ((left == 1 && carry_last) || left == 0) begin
        it.has_byte = (left == 1);
        it.last = 1'b1;
        send_item(it);
        break;
      end
      it.last = 1'b0;
      it.has_byte = ($urandom_range(0, 9) != 0);
      if (it.has_byte) begin
        left--;
      end
      send_item(it);
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return $urandom_range(0, 6);
    end else if (r < 88) begin
      return $urandom_range(7, MaxBytes - 1);
    end
    return $urandom_range(MaxBytes, MaxBytes + 6);
  endfunction

  initial begin
    msg_item_t   it;
    stim_row_t   row;
    int unsigned msg_no;
    int unsigned hdr_phase;
    int unsigned n_bytes;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == RowHeader) begin
        write_header(row.data_byte);
      end else begin
        for (int unsigned k = 0; k < row.reps; k++) begin
          it = '{row.frame_type, row.data_byte + 8'(k), row.has_byte, row.last};
          if (it.last) begin
            typed_frames_q.push_back(frame_typed_t'{row.len_typed, row.ovf_typed});
          end
          send_item(it);
        end
      end
    end

    // Random messages; the first two fill the buffer exactly and overrun it by one byte.
    msg_no = 0;
    hdr_phase = 0;
    while (sent_items < TotalItems) begin
      idle_on = !(sent_items >= 60 && sent_items < 110);
      if (msg_no % 6 == 5) begin
        case (hdr_phase % 4)
          0: write_header(8'h00);
          1: write_header(8'hFF);
          2: write_header(8'($urandom_range(0, 255)));
          default: write_header(cfpb_pkg::HeaderReset);
        endcase
        hdr_phase++;
      end
      if (msg_no == 0) begin
        n_bytes = MaxBytes;
      end else if (msg_no == 1) begin
        n_bytes = MaxBytes + 1;
      end else begin
        n_bytes = pick_length();
      end
      send_message(n_bytes);
      msg_no++;
    end

    idle_on = 1'b1;
    drain_frames();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
